>>> sv/texture_uv_partials_assert.svh
// Assertion macros shared by the texture UV partials RTL.
`ifndef TEXTURE_UV_PARTIALS_ASSERT_SVH
`define TEXTURE_UV_PARTIALS_ASSERT_SVH

// Same-cycle implication, reset masked.
`define TUP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("texture_uv_partials assertion failed");

// Next-cycle implication, reset masked.
`define TUP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("texture_uv_partials assertion failed");

`endif

>>> sv/tup_pkg.sv
// ----------------------------------------------------------------------------
// tup_pkg
// Shared types and constants of the texture UV partials block.
// ----------------------------------------------------------------------------
package tup_pkg;

    localparam int ADDR_W    = 6;
    localparam int MEM_DEPTH = 64;

    typedef logic [ADDR_W-1:0] addr_t;

    // vector slots
    localparam logic [2:0] SLOT_NORMAL = 3'd0;
    localparam logic [2:0] SLOT_HIT    = 3'd1;
    localparam logic [2:0] SLOT_DPDU   = 3'd2;
    localparam logic [2:0] SLOT_DPDV   = 3'd3;
    localparam logic [2:0] SLOT_XORG   = 3'd4;
    localparam logic [2:0] SLOT_XDIR   = 3'd5;
    localparam logic [2:0] SLOT_YORG   = 3'd6;
    localparam logic [2:0] SLOT_YDIR   = 3'd7;

    // scratch words above the vector store
    localparam addr_t T_ZERO = 6'd24;
    localparam addr_t T_ONE  = 6'd25;
    localparam addr_t T_ACC  = 6'd26;
    localparam addr_t T_PRD  = 6'd27;
    localparam addr_t T_D    = 6'd28;
    localparam addr_t T_RX   = 6'd29;
    localparam addr_t T_RY   = 6'd30;
    localparam addr_t T_NUM  = 6'd31;
    localparam addr_t T_T    = 6'd32;
    localparam addr_t T_PX   = 6'd33;
    localparam addr_t T_PY   = 6'd36;
    localparam addr_t T_BX0  = 6'd39;
    localparam addr_t T_BX1  = 6'd40;
    localparam addr_t T_BY0  = 6'd41;
    localparam addr_t T_BY1  = 6'd42;
    localparam addr_t T_DET  = 6'd43;
    localparam addr_t T_N0   = 6'd44;
    localparam addr_t T_N1   = 6'd45;
    localparam addr_t T_R0   = 6'd46;
    localparam addr_t T_R2   = 6'd48;

    typedef enum logic [3:0] {
        OP_MUL,   // floor((a*b) >> frac)
        OP_ADD,   // a + b, wide
        OP_SUB,   // a - b, wide
        OP_ADDS,  // sat32(a + b)
        OP_SUBS,  // sat32(a - b)
        OP_DIV,   // sat32((a << frac) / b)
        OP_ONE,   // 1.0
        OP_ISZ,   // flag = a == 0
        OP_AGT,   // flag = |a| > |b|
        OP_AGTT,  // flag = |a| > threshold
        OP_OUT    // result register <= a
    } op_t;

    typedef enum logic [1:0] {
        OUTC_COMPUTED = 2'd0,
        OUTC_NODIFF   = 2'd1,
        OUTC_PARALLEL = 2'd2
    } outc_t;

    typedef struct packed {
        logic       capture;
        logic       ld_we;
        logic [1:0] ld_comp;
        logic       rd;
        logic       ex;
        logic       div_go;
        logic       wb;
        op_t        op;
        addr_t      ra;
        addr_t      rb;
        addr_t      wa;
        logic [1:0] out_idx;
    } cmd_t;

    typedef struct packed {
        logic flag;
        logic div_done;
        logic slot7;
        logic rhd;
    } stat_t;

endpackage

>>> sv/tup_divider.sv
// ----------------------------------------------------------------------------
// tup_divider
// Restoring divider, one quotient bit a cycle: sat32((num << frac) / den).
// ----------------------------------------------------------------------------
module tup_divider #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_W    = 50
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic signed [WORD_W-1:0] num,
    input  logic signed [WORD_W-1:0] den,
    output logic signed [31:0]       q,
    output logic                     done
);

    localparam int NB = 33 + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam logic [NB-1:0] POS_MAX = NB'(64'd2147483647);
    localparam logic [NB-1:0] NEG_MAX = NB'(64'd2147483648);

    logic [NB-1:0]     dvd_reg;
    logic [NB-1:0]     quo_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic signed [31:0] q_reg;

    logic [WORD_W-1:0] num_mag;
    logic [WORD_W-1:0] den_mag;
    logic [WORD_W:0]   rem_sh;
    logic              fits;
    logic [WORD_W:0]   rem_step;
    logic signed [31:0] q_sat;
    logic [NB-1:0]     quo_neg;

    always_comb
    begin
        num_mag  = num[WORD_W-1] ? WORD_W'(-num) : WORD_W'(num);
        den_mag  = den[WORD_W-1] ? WORD_W'(-den) : WORD_W'(den);
        rem_sh   = {rem_reg, dvd_reg[NB-1]};
        fits     = rem_sh >= {1'b0, dvs_reg};
        rem_step = fits ? rem_sh - {1'b0, dvs_reg} : rem_sh;
        quo_neg  = NB'(~quo_reg + 1'b1);
        if (neg_reg)
        begin
            q_sat = (quo_reg > NEG_MAX) ? 32'sh8000_0000 : signed'(quo_neg[31:0]);
        end
        else
        begin
            q_sat = (quo_reg > POS_MAX) ? 32'sh7fff_ffff : signed'(quo_reg[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            cnt_reg  <= CW'(NB);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dvd_reg <= {num_mag[32:0], {FRAC_BITS{1'b0}}};
            dvs_reg <= den_mag;
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= num[WORD_W-1] ^ den[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                dvd_reg <= {dvd_reg[NB-2:0], 1'b0};
                rem_reg <= rem_step[WORD_W-1:0];
                quo_reg <= {quo_reg[NB-2:0], fits};
            end
            else
            begin
                q_reg <= q_sat;
            end
        end
    end

    assign q    = q_reg;
    assign done = done_reg;

endmodule

>>> sv/tup_datapath.sv
// ----------------------------------------------------------------------------
// tup_datapath
// Scratch memory, fixed-point ALU, divider and result registers.
// ----------------------------------------------------------------------------
module tup_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tup_pkg::cmd_t      cmd,
    output tup_pkg::stat_t     stat,
    input  logic [2:0]         vector_slot,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    input  logic               rays_have_differentials,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    output logic signed [31:0] du_dx,
    output logic signed [31:0] dv_dx,
    output logic signed [31:0] du_dy,
    output logic signed [31:0] dv_dy
);

    localparam int WW = 66 - FRAC_BITS;
    typedef logic signed [WW-1:0] word_t;
    localparam word_t SAT_HI = WW'(64'sd2147483647);
    localparam word_t SAT_LO = WW'(-64'sd2147483648);
    localparam word_t ONE_W  = WW'(64'sd1 <<< FRAC_BITS);

    function automatic logic signed [31:0] sat32(input word_t v);
        logic signed [31:0] r;
        if (v > SAT_HI)
        begin
            r = 32'sh7fff_ffff;
        end
        else if (v < SAT_LO)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    word_t mem [tup_pkg::MEM_DEPTH];

    logic [2:0]         slot_reg;
    logic signed [31:0] cx_reg;
    logic signed [31:0] cy_reg;
    logic signed [31:0] cz_reg;
    logic               rhd_reg;
    logic [15:0]        thr_reg;
    word_t              qa_reg;
    word_t              qb_reg;
    word_t              res_reg;
    logic               flag_reg;
    logic signed [31:0] out_reg [4];

    logic signed [63:0] prod;
    word_t              sum;
    word_t              dif;
    logic [WW-1:0]      mag_a;
    logic [WW-1:0]      mag_b;
    word_t              res_next;
    logic               flag_next;
    logic               we;
    tup_pkg::addr_t     wa;
    word_t              wd;
    logic signed [31:0] ld_val;
    logic signed [31:0] div_q;
    logic               div_done;

    tup_divider #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_W    (WW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd.div_go),
        .num   (qa_reg),
        .den   (qb_reg),
        .q     (div_q),
        .done  (div_done)
    );

    always_comb
    begin
        prod  = $signed(qa_reg[31:0]) * $signed(qb_reg[31:0]);
        sum   = qa_reg + qb_reg;
        dif   = qa_reg - qb_reg;
        mag_a = qa_reg[WW-1] ? WW'(-qa_reg) : WW'(qa_reg);
        mag_b = qb_reg[WW-1] ? WW'(-qb_reg) : WW'(qb_reg);
        res_next  = res_reg;
        flag_next = flag_reg;
        unique case (cmd.op)
            tup_pkg::OP_MUL:  res_next = WW'(prod >>> FRAC_BITS);
            tup_pkg::OP_ADD:  res_next = sum;
            tup_pkg::OP_SUB:  res_next = dif;
            tup_pkg::OP_ADDS: res_next = WW'(sat32(sum));
            tup_pkg::OP_SUBS: res_next = WW'(sat32(dif));
            tup_pkg::OP_ONE:  res_next = ONE_W;
            tup_pkg::OP_ISZ:  flag_next = (qa_reg == '0);
            tup_pkg::OP_AGT:  flag_next = (mag_a > mag_b);
            tup_pkg::OP_AGTT: flag_next = (mag_a > WW'(thr_reg));
            default:          res_next = res_reg;
        endcase
    end

    // write port: load words, else write-back
    always_comb
    begin
        unique case (cmd.ld_comp)
            2'd0:    ld_val = cx_reg;
            2'd1:    ld_val = cy_reg;
            default: ld_val = cz_reg;
        endcase
        we = cmd.ld_we;
        wa = tup_pkg::addr_t'({slot_reg, 1'b0}) + tup_pkg::addr_t'(slot_reg)
             + tup_pkg::addr_t'(cmd.ld_comp);
        wd = WW'(ld_val);
        if (!cmd.ld_we && cmd.wb)
        begin
            wa = cmd.wa;
            wd = (cmd.op == tup_pkg::OP_DIV) ? WW'(div_q) : res_reg;
            we = (cmd.op == tup_pkg::OP_MUL)  || (cmd.op == tup_pkg::OP_ADD)
              || (cmd.op == tup_pkg::OP_SUB)  || (cmd.op == tup_pkg::OP_ADDS)
              || (cmd.op == tup_pkg::OP_SUBS) || (cmd.op == tup_pkg::OP_DIV)
              || (cmd.op == tup_pkg::OP_ONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (cmd.rd)
        begin
            qa_reg <= mem[cmd.ra];
            qb_reg <= mem[cmd.rb];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg <= vector_slot;
            cx_reg   <= comp_x;
            cy_reg   <= comp_y;
            cz_reg   <= comp_z;
            rhd_reg  <= rays_have_differentials;
        end
        if (cmd.ex)
        begin
            res_reg  <= res_next;
            flag_reg <= flag_next;
        end
        if (cmd.wb && cmd.op == tup_pkg::OP_OUT)
        begin
            out_reg[cmd.out_idx] <= qa_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    assign stat.flag     = flag_reg;
    assign stat.div_done = div_done;
    assign stat.slot7    = (slot_reg == tup_pkg::SLOT_YDIR);
    assign stat.rhd      = rhd_reg;

    assign du_dx = out_reg[0];
    assign dv_dx = out_reg[1];
    assign du_dy = out_reg[2];
    assign dv_dy = out_reg[3];

endmodule

>>> sv/tup_ctrl.sv
// ----------------------------------------------------------------------------
// tup_ctrl
// Load sequencer and step program for the UV partials solve.
// ----------------------------------------------------------------------------
module tup_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output tup_pkg::cmd_t  cmd,
    input  tup_pkg::stat_t stat,
    output logic           done,
    output logic [1:0]     outcome,
    output logic           x_system_singular,
    output logic           y_system_singular
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_RD, S_EX, S_DW, S_WB, S_DONE} state_t;

    // program points
    localparam logic [6:0] PC_CHKD  = 7'd1;
    localparam logic [6:0] PC_ZRX   = 7'd18;
    localparam logic [6:0] PC_ZRY   = 7'd19;
    localparam logic [6:0] PC_A01   = 7'd48;
    localparam logic [6:0] PC_A02   = 7'd49;
    localparam logic [6:0] PC_A12   = 7'd50;
    localparam logic [6:0] PC_SING  = 7'd58;
    localparam logic [6:0] PC_XSOL  = 7'd59;
    localparam logic [6:0] PC_XEND  = 7'd66;
    localparam logic [6:0] PC_XFB   = 7'd67;
    localparam logic [6:0] PC_XFBE  = 7'd68;
    localparam logic [6:0] PC_YSOL  = 7'd69;
    localparam logic [6:0] PC_YEND  = 7'd76;
    localparam logic [6:0] PC_YFB   = 7'd77;
    localparam logic [6:0] PC_YFBE  = 7'd78;
    localparam logic [6:0] PC_OUT   = 7'd79;
    localparam logic [6:0] PC_LAST  = 7'd82;

    typedef struct packed {
        tup_pkg::op_t   op;
        tup_pkg::addr_t ra;
        tup_pkg::addr_t rb;
        tup_pkg::addr_t wa;
    } instr_t;

    function automatic tup_pkg::addr_t vaddr(input logic [2:0] s, input logic [1:0] c);
        return tup_pkg::addr_t'({s, 1'b0}) + tup_pkg::addr_t'(s) + tup_pkg::addr_t'(c);
    endfunction

    // five-step dot product, last step saturates into dst
    function automatic instr_t dot_step(input logic [6:0] k, input logic [2:0] s1,
                                        input logic [2:0] s2, input tup_pkg::addr_t dst);
        instr_t i;
        unique case (k[2:0])
            3'd0:    i = '{tup_pkg::OP_MUL, vaddr(s1, 2'd0), vaddr(s2, 2'd0), tup_pkg::T_ACC};
            3'd1:    i = '{tup_pkg::OP_MUL, vaddr(s1, 2'd1), vaddr(s2, 2'd1), tup_pkg::T_PRD};
            3'd2:    i = '{tup_pkg::OP_ADD, tup_pkg::T_ACC, tup_pkg::T_PRD, tup_pkg::T_ACC};
            3'd3:    i = '{tup_pkg::OP_MUL, vaddr(s1, 2'd2), vaddr(s2, 2'd2), tup_pkg::T_PRD};
            default: i = '{tup_pkg::OP_ADDS, tup_pkg::T_ACC, tup_pkg::T_PRD, dst};
        endcase
        return i;
    endfunction

    // plane point: o + t*dir per component
    function automatic instr_t pp_step(input logic [6:0] k, input logic [2:0] os,
                                       input logic [2:0] ds, input tup_pkg::addr_t dst);
        instr_t i;
        logic [1:0] c;
        c = k[2:1];
        if (!k[0])
        begin
            i = '{tup_pkg::OP_MUL, tup_pkg::T_T, vaddr(ds, c), tup_pkg::T_PRD};
        end
        else
        begin
            i = '{tup_pkg::OP_ADDS, vaddr(os, c), tup_pkg::T_PRD,
                  dst + tup_pkg::addr_t'(c)};
        end
        return i;
    endfunction

    // Cramer solve of one 2x2 system into r0, r0+1
    function automatic instr_t sv_step(input logic [6:0] k, input logic [1:0] a0,
                                       input logic [1:0] a1, input tup_pkg::addr_t b0,
                                       input tup_pkg::addr_t b1, input tup_pkg::addr_t r0);
        instr_t i;
        unique case (k[2:0])
            3'd0: i = '{tup_pkg::OP_MUL, vaddr(tup_pkg::SLOT_DPDV, a1), b0, tup_pkg::T_ACC};
            3'd1: i = '{tup_pkg::OP_MUL, vaddr(tup_pkg::SLOT_DPDV, a0), b1, tup_pkg::T_PRD};
            3'd2: i = '{tup_pkg::OP_SUBS, tup_pkg::T_ACC, tup_pkg::T_PRD, tup_pkg::T_N0};
            3'd3: i = '{tup_pkg::OP_MUL, vaddr(tup_pkg::SLOT_DPDU, a0), b1, tup_pkg::T_ACC};
            3'd4: i = '{tup_pkg::OP_MUL, vaddr(tup_pkg::SLOT_DPDU, a1), b0, tup_pkg::T_PRD};
            3'd5: i = '{tup_pkg::OP_SUBS, tup_pkg::T_ACC, tup_pkg::T_PRD, tup_pkg::T_N1};
            3'd6: i = '{tup_pkg::OP_DIV, tup_pkg::T_N0, tup_pkg::T_DET, r0};
            default: i = '{tup_pkg::OP_DIV, tup_pkg::T_N1, tup_pkg::T_DET,
                           r0 + tup_pkg::addr_t'(1)};
        endcase
        return i;
    endfunction

    state_t         state_reg, state_next;
    logic [6:0]     pc_reg, pc_next;
    logic [1:0]     comp_reg, comp_next;
    logic [1:0]     a0_reg, a0_next;
    logic [1:0]     a1_reg, a1_next;
    logic           f01_reg, f01_next;
    logic           f02_reg, f02_next;
    logic           sing_reg, sing_next;
    tup_pkg::outc_t outc_reg, outc_next;
    instr_t         ins;
    logic [6:0]     k;
    logic [1:0]     oi;

    // step program
    always_comb
    begin
        k   = '0;
        oi  = 2'(pc_reg - PC_OUT);
        ins = '{tup_pkg::OP_OUT, tup_pkg::T_ZERO, tup_pkg::T_ZERO, tup_pkg::T_ZERO};
        priority if (pc_reg == 7'd0)
            ins = '{tup_pkg::OP_SUB, vaddr(tup_pkg::SLOT_NORMAL, 2'd0),
                    vaddr(tup_pkg::SLOT_NORMAL, 2'd0), tup_pkg::T_ZERO};
        else if (pc_reg == PC_CHKD)
            ins = '{tup_pkg::OP_ONE, tup_pkg::T_ZERO, tup_pkg::T_ZERO, tup_pkg::T_ONE};
        else if (pc_reg <= 7'd6)
        begin
            k   = pc_reg - 7'd2;
            ins = dot_step(k, tup_pkg::SLOT_NORMAL, tup_pkg::SLOT_HIT, tup_pkg::T_D);
        end
        else if (pc_reg == 7'd7)
            ins = '{tup_pkg::OP_SUBS, tup_pkg::T_ZERO, tup_pkg::T_D, tup_pkg::T_D};
        else if (pc_reg <= 7'd12)
        begin
            k   = pc_reg - 7'd8;
            ins = dot_step(k, tup_pkg::SLOT_NORMAL, tup_pkg::SLOT_XDIR, tup_pkg::T_RX);
        end
        else if (pc_reg <= 7'd17)
        begin
            k   = pc_reg - 7'd13;
            ins = dot_step(k, tup_pkg::SLOT_NORMAL, tup_pkg::SLOT_YDIR, tup_pkg::T_RY);
        end
        else if (pc_reg == PC_ZRX)
            ins = '{tup_pkg::OP_ISZ, tup_pkg::T_RX, tup_pkg::T_ZERO, tup_pkg::T_ZERO};
        else if (pc_reg == PC_ZRY)
            ins = '{tup_pkg::OP_ISZ, tup_pkg::T_RY, tup_pkg::T_ZERO, tup_pkg::T_ZERO};
        else if (pc_reg <= 7'd24)
        begin
            k   = pc_reg - 7'd20;
            ins = dot_step(k, tup_pkg::SLOT_NORMAL, tup_pkg::SLOT_XORG, tup_pkg::T_NUM);
        end
        else if (pc_reg == 7'd25)
            ins = '{tup_pkg::OP_ADDS, tup_pkg::T_NUM, tup_pkg::T_D, tup_pkg::T_NUM};
        else if (pc_reg == 7'd26)
            ins = '{tup_pkg::OP_SUB, tup_pkg::T_ZERO, tup_pkg::T_NUM, tup_pkg::T_NUM};
        else if (pc_reg == 7'd27)
            ins = '{tup_pkg::OP_DIV, tup_pkg::T_NUM, tup_pkg::T_RX, tup_pkg::T_T};
        else if (pc_reg <= 7'd33)
        begin
            k   = pc_reg - 7'd28;
            ins = pp_step(k, tup_pkg::SLOT_XORG, tup_pkg::SLOT_XDIR, tup_pkg::T_PX);
        end
        else if (pc_reg <= 7'd38)
        begin
            k   = pc_reg - 7'd34;
            ins = dot_step(k, tup_pkg::SLOT_NORMAL, tup_pkg::SLOT_YORG, tup_pkg::T_NUM);
        end
        else if (pc_reg == 7'd39)
            ins = '{tup_pkg::OP_ADDS, tup_pkg::T_NUM, tup_pkg::T_D, tup_pkg::T_NUM};
        else if (pc_reg == 7'd40)
            ins = '{tup_pkg::OP_SUB, tup_pkg::T_ZERO, tup_pkg::T_NUM, tup_pkg::T_NUM};
        else if (pc_reg == 7'd41)
            ins = '{tup_pkg::OP_DIV, tup_pkg::T_NUM, tup_pkg::T_RY, tup_pkg::T_T};
        else if (pc_reg <= 7'd47)
        begin
            k   = pc_reg - 7'd42;
            ins = pp_step(k, tup_pkg::SLOT_YORG, tup_pkg::SLOT_YDIR, tup_pkg::T_PY);
        end
        else if (pc_reg == PC_A01)
            ins = '{tup_pkg::OP_AGT, vaddr(tup_pkg::SLOT_NORMAL, 2'd0),
                    vaddr(tup_pkg::SLOT_NORMAL, 2'd1), tup_pkg::T_ZERO};
        else if (pc_reg == PC_A02)
            ins = '{tup_pkg::OP_AGT, vaddr(tup_pkg::SLOT_NORMAL, 2'd0),
                    vaddr(tup_pkg::SLOT_NORMAL, 2'd2), tup_pkg::T_ZERO};
        else if (pc_reg == PC_A12)
            ins = '{tup_pkg::OP_AGT, vaddr(tup_pkg::SLOT_NORMAL, 2'd1),
                    vaddr(tup_pkg::SLOT_NORMAL, 2'd2), tup_pkg::T_ZERO};
        else if (pc_reg == 7'd51)
            ins = '{tup_pkg::OP_SUBS, tup_pkg::T_PX + tup_pkg::addr_t'(a0_reg),
                    vaddr(tup_pkg::SLOT_HIT, a0_reg), tup_pkg::T_BX0};
        else if (pc_reg == 7'd52)
            ins = '{tup_pkg::OP_SUBS, tup_pkg::T_PX + tup_pkg::addr_t'(a1_reg),
                    vaddr(tup_pkg::SLOT_HIT, a1_reg), tup_pkg::T_BX1};
        else if (pc_reg == 7'd53)
            ins = '{tup_pkg::OP_SUBS, tup_pkg::T_PY + tup_pkg::addr_t'(a0_reg),
                    vaddr(tup_pkg::SLOT_HIT, a0_reg), tup_pkg::T_BY0};
        else if (pc_reg == 7'd54)
            ins = '{tup_pkg::OP_SUBS, tup_pkg::T_PY + tup_pkg::addr_t'(a1_reg),
                    vaddr(tup_pkg::SLOT_HIT, a1_reg), tup_pkg::T_BY1};
        else if (pc_reg == 7'd55)
            ins = '{tup_pkg::OP_MUL, vaddr(tup_pkg::SLOT_DPDU, a0_reg),
                    vaddr(tup_pkg::SLOT_DPDV, a1_reg), tup_pkg::T_ACC};
        else if (pc_reg == 7'd56)
            ins = '{tup_pkg::OP_MUL, vaddr(tup_pkg::SLOT_DPDV, a0_reg),
                    vaddr(tup_pkg::SLOT_DPDU, a1_reg), tup_pkg::T_PRD};
        else if (pc_reg == 7'd57)
            ins = '{tup_pkg::OP_SUB, tup_pkg::T_ACC, tup_pkg::T_PRD, tup_pkg::T_DET};
        else if (pc_reg == PC_SING)
            ins = '{tup_pkg::OP_AGTT, tup_pkg::T_DET, tup_pkg::T_ZERO, tup_pkg::T_ZERO};
        else if (pc_reg <= PC_XEND)
        begin
            k   = pc_reg - PC_XSOL;
            ins = sv_step(k, a0_reg, a1_reg, tup_pkg::T_BX0, tup_pkg::T_BX1, tup_pkg::T_R0);
        end
        else if (pc_reg == PC_XFB)
            ins = '{tup_pkg::OP_ADD, tup_pkg::T_ONE, tup_pkg::T_ZERO, tup_pkg::T_R0};
        else if (pc_reg == PC_XFBE)
            ins = '{tup_pkg::OP_ADD, tup_pkg::T_ZERO, tup_pkg::T_ZERO,
                    tup_pkg::T_R0 + tup_pkg::addr_t'(1)};
        else if (pc_reg <= PC_YEND)
        begin
            k   = pc_reg - PC_YSOL;
            ins = sv_step(k, a0_reg, a1_reg, tup_pkg::T_BY0, tup_pkg::T_BY1, tup_pkg::T_R2);
        end
        else if (pc_reg == PC_YFB)
            ins = '{tup_pkg::OP_ADD, tup_pkg::T_ZERO, tup_pkg::T_ZERO, tup_pkg::T_R2};
        else if (pc_reg == PC_YFBE)
            ins = '{tup_pkg::OP_ADD, tup_pkg::T_ONE, tup_pkg::T_ZERO,
                    tup_pkg::T_R2 + tup_pkg::addr_t'(1)};
        else
        begin
            // result copy; zeros unless the outcome is COMPUTED
            ins.op = tup_pkg::OP_OUT;
            ins.ra = (outc_reg == tup_pkg::OUTC_COMPUTED)
                     ? tup_pkg::T_R0 + tup_pkg::addr_t'(oi) : tup_pkg::T_ZERO;
        end
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        comp_next  = comp_reg;
        a0_next    = a0_reg;
        a1_next    = a1_reg;
        f01_next   = f01_reg;
        f02_next   = f02_reg;
        sing_next  = sing_reg;
        outc_next  = outc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                comp_next = 2'd0;
                if (start)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd2)
                begin
                    pc_next    = '0;
                    outc_next  = tup_pkg::OUTC_COMPUTED;
                    sing_next  = 1'b0;
                    state_next = stat.slot7 ? S_RD : S_IDLE;
                end
            end
            S_RD:
            begin
                state_next = S_EX;
            end
            S_EX:
            begin
                state_next = (ins.op == tup_pkg::OP_DIV) ? S_DW : S_WB;
            end
            S_DW:
            begin
                if (stat.div_done)
                begin
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                state_next = S_RD;
                pc_next    = pc_reg + 7'd1;
                priority if (pc_reg == PC_CHKD && !stat.rhd)
                begin
                    outc_next = tup_pkg::OUTC_NODIFF;
                    pc_next   = PC_OUT;
                end
                else if ((pc_reg == PC_ZRX || pc_reg == PC_ZRY) && stat.flag)
                begin
                    outc_next = tup_pkg::OUTC_PARALLEL;
                    pc_next   = PC_OUT;
                end
                else if (pc_reg == PC_A01)
                    f01_next = stat.flag;
                else if (pc_reg == PC_A02)
                    f02_next = stat.flag;
                else if (pc_reg == PC_A12)
                begin
                    // drop the axis where the normal is largest
                    if (f01_reg && f02_reg)
                    begin
                        a0_next = 2'd1;
                        a1_next = 2'd2;
                    end
                    else if (stat.flag)
                    begin
                        a0_next = 2'd0;
                        a1_next = 2'd2;
                    end
                    else
                    begin
                        a0_next = 2'd0;
                        a1_next = 2'd1;
                    end
                end
                else if (pc_reg == PC_SING)
                begin
                    sing_next = !stat.flag;
                    pc_next   = stat.flag ? PC_XSOL : PC_XFB;
                end
                else if (pc_reg == PC_XEND || pc_reg == PC_XFBE)
                    pc_next = sing_reg ? PC_YFB : PC_YSOL;
                else if (pc_reg == PC_YEND || pc_reg == PC_YFBE)
                    pc_next = PC_OUT;
                else if (pc_reg == PC_LAST)
                    state_next = S_DONE;
                else
                    pc_next = pc_reg + 7'd1;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            comp_reg  <= '0;
            a0_reg    <= '0;
            a1_reg    <= '0;
            f01_reg   <= 1'b0;
            f02_reg   <= 1'b0;
            sing_reg  <= 1'b0;
            outc_reg  <= tup_pkg::OUTC_COMPUTED;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            comp_reg  <= comp_next;
            a0_reg    <= a0_next;
            a1_reg    <= a1_next;
            f01_reg   <= f01_next;
            f02_reg   <= f02_next;
            sing_reg  <= sing_next;
            outc_reg  <= outc_next;
        end
    end

    always_comb
    begin
        cmd.capture = (state_reg == S_IDLE) && start;
        cmd.ld_we   = (state_reg == S_LOAD);
        cmd.ld_comp = comp_reg;
        cmd.rd      = (state_reg == S_RD);
        cmd.ex      = (state_reg == S_EX);
        cmd.div_go  = (state_reg == S_EX) && (ins.op == tup_pkg::OP_DIV);
        cmd.wb      = (state_reg == S_WB);
        cmd.op      = ins.op;
        cmd.ra      = ins.ra;
        cmd.rb      = ins.rb;
        cmd.wa      = ins.wa;
        cmd.out_idx = oi;
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = (state_reg == S_DONE);
    assign outcome           = outc_reg;
    assign x_system_singular = sing_reg && (outc_reg == tup_pkg::OUTC_COMPUTED);
    assign y_system_singular = sing_reg && (outc_reg == tup_pkg::OUTC_COMPUTED);

`include "texture_uv_partials_assert.svh"

    `TUP_ASSERT_NEXT(a_done_pulse, done, !done)
    `TUP_ASSERT_NOW(a_sing_only_computed, done && x_system_singular, outcome == tup_pkg::OUTC_COMPUTED)
    `TUP_ASSERT_NEXT(a_capture_busy, start && !busy, busy && state_reg == S_LOAD)
    `TUP_ASSERT_NOW(a_div_wait_op, state_reg == S_DW, ins.op == tup_pkg::OP_DIV)

endmodule

>>> sv/texture_uv_partials.sv
// ----------------------------------------------------------------------------
// texture_uv_partials
// Texture UV partials from ray differentials, signed fixed point.
// ----------------------------------------------------------------------------
// Load item: busy while its three words are written; the next item is taken only after that.
// Slot-7 item: the step sequencer reads, executes and writes back each
//   program step (up to 79 steps) and waits on the bit-serial divider
//   for each division (up to six); FRAC_BITS = 16 gives Q16.16.
// done pulses one cycle with the result; the receiver cannot stall.
// Reset: controller idle, threshold 0; vector store holds no reset value.
module texture_uv_partials #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         vector_slot,
    input  logic signed [31:0] comp_x,
    input  logic signed [31:0] comp_y,
    input  logic signed [31:0] comp_z,
    input  logic               rays_have_differentials,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] du_dx,
    output logic signed [31:0] dv_dx,
    output logic signed [31:0] du_dy,
    output logic signed [31:0] dv_dy,
    output logic [1:0]         outcome,
    output logic               x_system_singular,
    output logic               y_system_singular
);

    tup_pkg::cmd_t  cmd;
    tup_pkg::stat_t stat;

    // threshold register is always writable; config is to land only while idle, which the user must ensure
    assign cfg_ready = 1'b1;

    // Controller: load sequencing (three word writes per item) and the
    // step program (dot products, plane hits, axis choice, two solves).
    tup_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .cmd               (cmd),
        .stat              (stat),
        .done              (done),
        .outcome           (outcome),
        .x_system_singular (x_system_singular),
        .y_system_singular (y_system_singular)
    );

    // Datapath: vector/scratch memory, ALU with one 32x32 multiplier,
    // shared divider, result registers.
    tup_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cmd                     (cmd),
        .stat                    (stat),
        .vector_slot             (vector_slot),
        .comp_x                  (comp_x),
        .comp_y                  (comp_y),
        .comp_z                  (comp_z),
        .rays_have_differentials (rays_have_differentials),
        .cfg_we                  (cfg_valid),
        .cfg_data                (cfg_data),
        .du_dx                   (du_dx),
        .dv_dx                   (dv_dx),
        .du_dy                   (du_dy),
        .dv_dy                   (dv_dy)
    );

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for texture_uv_partials: a directed table and random
// eight-vector load sets and lone loads, checked against a Q16.16 partials predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int FRAC      = 16;
    localparam int ONE       = 1 << FRAC;
    localparam int N_RANDOM  = 1130;
    localparam int CYC_LIMIT = 3000000;
    localparam int DRAIN     = 600;     // about one slot-7 computation
    localparam int I32_MAX   = 32'h7fffffff;
    localparam int I32_MIN   = 32'h80000000;

    // one result item
    typedef struct {
        logic signed [31:0] du_dx;
        logic signed [31:0] dv_dx;
        logic signed [31:0] du_dy;
        logic signed [31:0] dv_dy;
        tup_pkg::outc_t     outcome;
        logic               xs;
        logic               ys;
    } partials_t;

    // one row of the directed table
    typedef struct {
        logic [2:0]     slot;
        logic [31:0]    x;
        logic [31:0]    y;
        logic [31:0]    z;
        logic           rhd;
        bit             typed;     // expected result written in the row
        tup_pkg::outc_t outc;
    } load_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         vector_slot;
    logic signed [31:0] comp_x;
    logic signed [31:0] comp_y;
    logic signed [31:0] comp_z;
    logic               rays_have_differentials;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [15:0]        cfg_data;
    logic               done;
    logic signed [31:0] du_dx;
    logic signed [31:0] dv_dx;
    logic signed [31:0] du_dy;
    logic signed [31:0] dv_dy;
    logic [1:0]         outcome;
    logic               x_system_singular;
    logic               y_system_singular;

    // predictor state
    logic [31:0] vec_model [24];
    logic [15:0] thresh_model;

    partials_t pending_partials [$];
    int        fail_count;
    int        cycle_count;
    bit        idle_enable;

    texture_uv_partials dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .start                   (start),
        .busy                    (busy),
        .vector_slot             (vector_slot),
        .comp_x                  (comp_x),
        .comp_y                  (comp_y),
        .comp_z                  (comp_z),
        .rays_have_differentials (rays_have_differentials),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_data                (cfg_data),
        .done                    (done),
        .du_dx                   (du_dx),
        .dv_dx                   (dv_dx),
        .du_dy                   (du_dy),
        .dv_dy                   (dv_dy),
        .outcome                 (outcome),
        .x_system_singular       (x_system_singular),
        .y_system_singular       (y_system_singular)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------
    // fixed-point helpers, all in 64-bit signed
    // ------------------------------------------------------------------
    function automatic longint sat32(longint v);
        if (v > longint'(I32_MAX))
            return longint'(I32_MAX);
        if (v < longint'(I32_MIN))
            return longint'(I32_MIN);
        return v;
    endfunction

    // arithmetic shift on a signed value floors
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic longint fx_div(longint num, longint den);
        return sat32((num * (longint'(1) << FRAC)) / den);
    endfunction

    function automatic longint vcomp(int slot, int c);
        return longint'($signed(vec_model[slot * 3 + c]));
    endfunction

    function automatic longint vdot(int s1, int s2);
        longint sum;
        sum = 0;
        for (int c = 0; c < 3; c++)
            sum += fx_mul(vcomp(s1, c), vcomp(s2, c));
        return sat32(sum);
    endfunction

    // 2x2 solve; returns 0 when singular
    function automatic bit solve_2x2(longint a00, longint a01, longint a10,
                                     longint a11, longint b0, longint b1,
                                     output longint r0, output longint r1);
        longint det;
        longint mag;
        det = fx_mul(a00, a11) - fx_mul(a01, a10);
        mag = (det < 0) ? -det : det;
        r0 = 0;
        r1 = 0;
        if (mag <= longint'(thresh_model))
            return 0;
        r0 = fx_div(sat32(fx_mul(a11, b0) - fx_mul(a01, b1)), det);
        r1 = fx_div(sat32(fx_mul(a00, b1) - fx_mul(a10, b0)), det);
        return 1;
    endfunction

    // intersection of one offset ray with the tangent plane
    function automatic void plane_hit(int os, int ds, longint d, longint rd,
                                      output longint pt [3]);
        longint t;
        t = fx_div(-sat32(vdot(0, os) + d), rd);
        for (int c = 0; c < 3; c++)
            pt[c] = sat32(vcomp(os, c) + fx_mul(t, vcomp(ds, c)));
    endfunction

    function automatic partials_t predict_partials(logic rhd);
        partials_t p;
        longint    d, rx, ry, r0, r1;
        longint    px [3];
        longint    py [3];
        longint    an [3];
        int        a0, a1;
        p = '{0, 0, 0, 0, tup_pkg::OUTC_COMPUTED, 1'b0, 1'b0};
        if (!rhd)
        begin
            p.outcome = tup_pkg::OUTC_NODIFF;
            return p;
        end
        d  = sat32(-vdot(0, 1));
        rx = vdot(0, 5);
        ry = vdot(0, 7);
        if (rx == 0 || ry == 0)
        begin
            p.outcome = tup_pkg::OUTC_PARALLEL;
            return p;
        end
        plane_hit(4, 5, d, rx, px);
        plane_hit(6, 7, d, ry, py);
        for (int k = 0; k < 3; k++)
        begin
            an[k] = vcomp(0, k);
            if (an[k] < 0)
                an[k] = -an[k];
        end
        // project onto the two axes where the normal is smallest
        if (an[0] > an[1] && an[0] > an[2])
        begin
            a0 = 1;
            a1 = 2;
        end
        else if (an[1] > an[2])
        begin
            a0 = 0;
            a1 = 2;
        end
        else
        begin
            a0 = 0;
            a1 = 1;
        end
        if (solve_2x2(vcomp(2, a0), vcomp(3, a0), vcomp(2, a1), vcomp(3, a1),
                      sat32(px[a0] - vcomp(1, a0)), sat32(px[a1] - vcomp(1, a1)),
                      r0, r1))
        begin
            p.du_dx = r0[31:0];
            p.dv_dx = r1[31:0];
        end
        else
        begin
            p.du_dx = ONE;
            p.xs    = 1'b1;
        end
        if (solve_2x2(vcomp(2, a0), vcomp(3, a0), vcomp(2, a1), vcomp(3, a1),
                      sat32(py[a0] - vcomp(1, a0)), sat32(py[a1] - vcomp(1, a1)),
                      r0, r1))
        begin
            p.du_dy = r0[31:0];
            p.dv_dy = r1[31:0];
        end
        else
        begin
            p.dv_dy = ONE;
            p.ys    = 1'b1;
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // drivers; called at a falling edge, return at a falling edge
    // ------------------------------------------------------------------
    task automatic send_load(logic [2:0] slot, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic rhd, bit typed,
                             tup_pkg::outc_t outc);
        partials_t p;
        int        gap;
        if (idle_enable && $urandom_range(0, 99) < 36)
        begin
            start = 1'b0;
            gap   = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        start                   = 1'b1;
        vector_slot             = slot;
        comp_x                  = x;
        comp_y                  = y;
        comp_z                  = z;
        rays_have_differentials = rhd;
        do
            @(posedge clk);
        while (busy);
        // item accepted at this edge
        vec_model[slot * 3 + 0] = x;
        vec_model[slot * 3 + 1] = y;
        vec_model[slot * 3 + 2] = z;
        if (slot == tup_pkg::SLOT_YDIR)
        begin
            p = predict_partials(rhd);
            if (typed)
                p = '{0, 0, 0, 0, outc, 1'b0, 1'b0};
            pending_partials.push_back(p);
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    // threshold write, only with nothing in flight
    task automatic write_threshold(logic [15:0] value);
        while (pending_partials.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        thresh_model = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h7ffff) - 32'h40000;
            5:             return $urandom_range(0, 32'hfff) << $urandom_range(0, 16);
            6:             return $urandom;
            7:             return 32'h0;
            8:             return $urandom_range(0, 1) ? I32_MAX : I32_MIN;
            default:       return ($urandom_range(0, 8) - 4) * ONE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checker; done is sampled before the edge updates it
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        partials_t e;
        if (rst_n && done)
        begin
            if (pending_partials.size() == 0)
            begin
                $error("unexpected result item");
                fail_count++;
            end
            else
            begin
                e = pending_partials.pop_front();
                if (du_dx !== e.du_dx)
                begin
                    $error("du_dx expected %h actual %h", e.du_dx, du_dx);
                    fail_count++;
                end
                if (dv_dx !== e.dv_dx)
                begin
                    $error("dv_dx expected %h actual %h", e.dv_dx, dv_dx);
                    fail_count++;
                end
                if (du_dy !== e.du_dy)
                begin
                    $error("du_dy expected %h actual %h", e.du_dy, du_dy);
                    fail_count++;
                end
                if (dv_dy !== e.dv_dy)
                begin
                    $error("dv_dy expected %h actual %h", e.dv_dy, dv_dy);
                    fail_count++;
                end
                if (outcome !== e.outcome)
                begin
                    $error("outcome expected %0d actual %0d", e.outcome, outcome);
                    fail_count++;
                end
                if (x_system_singular !== e.xs)
                begin
                    $error("x_system_singular expected %b actual %b", e.xs,
                           x_system_singular);
                    fail_count++;
                end
                if (y_system_singular !== e.ys)
                begin
                    $error("y_system_singular expected %b actual %b", e.ys,
                           y_system_singular);
                    fail_count++;
                end
            end
        end
    end

    // run time guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    load_row_t directed [] = '{
        // full set first so no unwritten entry is ever read
        '{tup_pkg::SLOT_NORMAL, 0, 0, ONE, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_HIT, 0, 0, 0, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_DPDU, ONE, 0, 0, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_DPDV, 0, ONE, 0, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_XORG, ONE / 8, 0, 2 * ONE, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_XDIR, 0, 0, -ONE, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_YORG, 0, ONE / 8, 2 * ONE, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        // no differentials
        '{tup_pkg::SLOT_YDIR, 0, 0, -ONE, 1'b0, 1'b1, tup_pkg::OUTC_NODIFF},
        '{tup_pkg::SLOT_YDIR, 0, 0, -ONE, 1'b1, 1'b0, tup_pkg::OUTC_COMPUTED},
        // x ray parallel to the plane
        '{tup_pkg::SLOT_XDIR, ONE, 0, 0, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_YDIR, 0, 0, -ONE, 1'b1, 1'b1, tup_pkg::OUTC_PARALLEL},
        '{tup_pkg::SLOT_XDIR, 0, 0, -ONE, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        // axis choice: x greatest, y greatest, ties
        '{tup_pkg::SLOT_NORMAL, ONE, ONE / 2, ONE / 4, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_YDIR, -ONE, ONE / 4, -ONE, 1'b1, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_NORMAL, ONE / 4, -ONE, ONE / 2, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_YDIR, ONE / 4, -ONE, -ONE, 1'b1, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_NORMAL, ONE, -ONE, ONE, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_YDIR, 0, ONE / 2, -ONE, 1'b1, 1'b0, tup_pkg::OUTC_COMPUTED},
        // singular systems: dpdv along dpdu
        '{tup_pkg::SLOT_DPDV, ONE, 0, 0, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_YDIR, 0, 0, -ONE, 1'b1, 1'b0, tup_pkg::OUTC_COMPUTED},
        // field extremes
        '{tup_pkg::SLOT_NORMAL, I32_MAX, I32_MIN, I32_MAX, 1'b0, 1'b0,
          tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_XORG, I32_MIN, I32_MAX, I32_MIN, 1'b0, 1'b0,
          tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_DPDV, I32_MIN, I32_MAX, -1, 1'b0, 1'b0, tup_pkg::OUTC_COMPUTED},
        '{tup_pkg::SLOT_YDIR, I32_MIN, I32_MIN, I32_MAX, 1'b1, 1'b0,
          tup_pkg::OUTC_COMPUTED}
    };

    initial
    begin
        logic [15:0] phase_thresh [4];
        int          per_phase;
        int          n_sent;
        int          slot_order [8];
        int          j, tmp, k;

        start                   = 1'b0;
        vector_slot             = tup_pkg::SLOT_NORMAL;
        comp_x                  = 0;
        comp_y                  = 0;
        comp_z                  = 0;
        rays_have_differentials = 1'b0;
        cfg_valid               = 1'b0;
        cfg_data                = 16'h0;
        rst_n                   = 1'b0;
        fail_count              = 0;
        cycle_count             = 0;
        idle_enable             = 1'b1;
        thresh_model            = 16'h0;
        for (int i = 0; i < 24; i++)
            vec_model[i] = 32'h0;

        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_threshold(16'h0);
        foreach (directed[i])
            send_load(directed[i].slot, directed[i].x, directed[i].y,
                      directed[i].z, directed[i].rhd, directed[i].typed,
                      directed[i].outc);

        // random phases over several thresholds, extremes included
        phase_thresh[0] = 16'hffff;
        phase_thresh[1] = 16'h0001;
        phase_thresh[2] = 16'($urandom_range(0, 16'hffff));
        phase_thresh[3] = 16'h0000;
        per_phase       = N_RANDOM / 4;
        n_sent          = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            write_threshold(phase_thresh[ph]);
            k = 0;
            while (k < per_phase)
            begin
                // a stretch with no sender gaps
                idle_enable = !(n_sent >= 400 && n_sent < 600);
                if ($urandom_range(0, 9) < 8)
                begin
                    // well-formed set: slots 0..6 shuffled, slot 7 last
                    for (int s = 0; s < 7; s++)
                        slot_order[s] = s;
                    for (int s = 6; s > 0; s--)
                    begin
                        j             = $urandom_range(0, s);
                        tmp           = slot_order[s];
                        slot_order[s] = slot_order[j];
                        slot_order[j] = tmp;
                    end
                    slot_order[7] = tup_pkg::SLOT_YDIR;
                    for (int s = 0; s < 8; s++)
                        send_load(3'(slot_order[s]), rand_comp(), rand_comp(),
                                  rand_comp(), $urandom_range(0, 9) != 0, 1'b0,
                                  tup_pkg::OUTC_COMPUTED);
                    k      += 8;
                    n_sent += 8;
                end
                else
                begin
                    // noise: a lone load of any slot, content fully random
                    send_load(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                              1'($urandom_range(0, 1)), 1'b0, tup_pkg::OUTC_COMPUTED);
                    k++;
                    n_sent++;
                end
            end
        end

        while (pending_partials.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
